### rtl/core/inikey_pkg.sv
package inikey_pkg;

   // Characters that steer the scanner.
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTION_NAME   = 2'd0,
      CSR_SECTION_LENGTH = 2'd1,
      CSR_KEY_NAME       = 2'd2,
      CSR_KEY_LENGTH     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } text_beat_type;

   typedef struct packed {
      logic        found;
      logic [63:0] value_bytes;
      logic [3:0]  value_length;
      logic        value_overflow;
   } result_beat_type;

endpackage

### rtl/core/ini_section_key_lookup.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_text_byte, req_is_last
// rsp      out        rsp_valid/rsp_stall  rsp_found, rsp_value_bytes,
//                                          rsp_value_length, rsp_value_overflow
// csr      in         csr_write_enable     csr_index, csr_data
//
// One text byte is taken per cycle while req_stall is low; a beat passes an input
// register, is scanned combinationally against the state registers, and any
// result lands in the output register, which drives rsp_valid.
// Reset clears the configuration to zero and the scanner to a line start.
// A stalled result holds the output register, and the byte behind it then
// waits in the input register; req_stall is high while that register holds a
// byte that the scanner cannot take, so at most one more byte is taken.
module ini_section_key_lookup #(
   parameter int NAME_BYTES  = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_text_byte,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_found,
   output logic [63:0]                        rsp_value_bytes,
   output logic [3:0]                         rsp_value_length,
   output logic                               rsp_value_overflow,
   input  logic                               csr_write_enable,
   input  logic [inikey_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                        csr_data
);
   import inikey_pkg::*;

   logic            take;
   logic            beat_valid;
   text_beat_type   beat;
   logic            result_valid;
   result_beat_type result;

   inikey_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_is_last   (req_is_last),
      .take          (take),
      .beat_valid    (beat_valid),
      .beat          (beat)
   );

   inikey_scan #(
      .NAME_BYTES  (NAME_BYTES),
      .VALUE_BYTES (VALUE_BYTES)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .beat_valid       (beat_valid),
      .beat             (beat),
      .advance          (take),
      .result_valid     (result_valid),
      .result           (result)
   );

   inikey_out_stage u_out_stage (
      .clock              (clock),
      .reset              (reset),
      .result_valid       (result_valid),
      .result             (result),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_value_bytes    (rsp_value_bytes),
      .rsp_value_length   (rsp_value_length),
      .rsp_value_overflow (rsp_value_overflow)
   );

endmodule

### rtl/core/inikey_in_stage.sv
module inikey_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_is_last,
   input  logic                   take,
   output logic                   beat_valid,
   output inikey_pkg::text_beat_type beat
);
   import inikey_pkg::*;

   logic          valid_ff;
   text_beat_type beat_ff;

   // The held beat leaves when the scanner takes it, which frees the slot.
   assign req_stall  = valid_ff && !take;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         beat_ff.text_byte <= req_text_byte;
         beat_ff.is_last   <= req_is_last;
      end
   end

endmodule

### rtl/core/inikey_scan.sv
module inikey_scan #(
   parameter int NAME_BYTES  = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [inikey_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data,
   input  logic                            beat_valid,
   input  inikey_pkg::text_beat_type       beat,
   input  logic                            advance,
   output logic                            result_valid,
   output inikey_pkg::result_beat_type     result
);
   import inikey_pkg::*;

   localparam int NBUF_W = 8 * NAME_BYTES;
   localparam int VBUF_W = 8 * VALUE_BYTES;
   localparam int NCNT_W = $clog2(NAME_BYTES + 1);
   localparam int VCNT_W = $clog2(VALUE_BYTES + 1);

   typedef struct packed {
      logic comment;
      logic section;
      logic key;
      logic value;
      logic line_start;
      logic sec_match;
      logic key_match;
   } mode_type;

   localparam mode_type MODE_START = '{
      comment:    1'b0,
      section:    1'b0,
      key:        1'b0,
      value:      1'b0,
      line_start: 1'b1,
      sec_match:  1'b0,
      key_match:  1'b0
   };

   logic [63:0]       section_name_ff;
   logic [3:0]        section_length_ff;
   logic [63:0]       key_name_ff;
   logic [3:0]        key_length_ff;

   mode_type          mode_ff,  mode_in;
   logic [NBUF_W-1:0] nbuf_ff,  nbuf_in;
   logic [NCNT_W-1:0] ncnt_ff,  ncnt_in;
   logic              ntl_ff,   ntl_in;
   logic [VBUF_W-1:0] vbuf_ff,  vbuf_in;
   logic [VCNT_W-1:0] vcnt_ff,  vcnt_in;
   logic              vcut_ff,  vcut_in;
   logic              done_ff,  done_in;

   logic              emit;
   logic              not_found;
   logic              sec_hit;
   logic              key_hit;
   logic              line_start_now;
   logic [7:0]        c;

   // A name matches only at exactly the configured length and bytes.
   function automatic logic name_match(
      input logic [NBUF_W-1:0] buf_bytes,
      input logic [NCNT_W-1:0] count,
      input logic              too_long,
      input logic [63:0]       want,
      input logic [3:0]        want_len
   );
      logic [NBUF_W-1:0] masked;
      masked = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (4'(i) < want_len) begin
            masked[8*i +: 8] = want[8*i +: 8];
         end
      end
      return !too_long && (want_len == 4'(count)) && (buf_bytes == masked);
   endfunction

   assign sec_hit = name_match(nbuf_ff, ncnt_ff, ntl_ff, section_name_ff,
                               section_length_ff);
   assign c       = beat.text_byte;

   always_comb begin
      mode_in        = mode_ff;
      nbuf_in        = nbuf_ff;
      ncnt_in        = ncnt_ff;
      ntl_in         = ntl_ff;
      vbuf_in        = vbuf_ff;
      vcnt_in        = vcnt_ff;
      vcut_in        = vcut_ff;
      done_in        = done_ff;
      emit           = 1'b0;
      key_hit        = 1'b0;
      line_start_now = mode_ff.line_start;

      if (!done_ff) begin
         if (!mode_ff.comment) begin
            if (c == CHAR_HASH) begin
               mode_in.comment = 1'b1;
            end else begin
               if (c == CHAR_LBRACK && line_start_now) begin
                  mode_in.sec_match = 1'b0;
                  mode_in.section   = 1'b1;
                  nbuf_in = '0;
                  ncnt_in = '0;
                  ntl_in  = 1'b0;
               end
               if (c != CHAR_LBRACK && line_start_now && mode_in.sec_match) begin
                  mode_in.key = 1'b1;
                  nbuf_in = '0;
                  ncnt_in = '0;
                  ntl_in  = 1'b0;
               end
               if (c == CHAR_RBRACK && mode_in.section) begin
                  mode_in.section = 1'b0;
                  if (sec_hit) begin
                     mode_in.sec_match = 1'b1;
                  end
               end
               if (c == CHAR_EQUALS && mode_in.key) begin
                  // The name may have been cleared by a key start in this beat.
                  key_hit = name_match(nbuf_in, ncnt_in, ntl_in, key_name_ff,
                                       key_length_ff);
                  mode_in.key       = 1'b0;
                  mode_in.value     = 1'b1;
                  mode_in.key_match = key_hit;
                  vbuf_in = '0;
                  vcnt_in = '0;
                  vcut_in = 1'b0;
               end
               if ((c == CHAR_NEWLINE || c == CHAR_TAB || c == CHAR_SPACE) &&
                   mode_in.value && mode_in.sec_match && mode_in.key_match) begin
                  emit    = 1'b1;
                  done_in = 1'b1;
               end else begin
                  if ((mode_in.section && c != CHAR_LBRACK) || mode_in.key) begin
                     if (ncnt_in < NCNT_W'(NAME_BYTES)) begin
                        for (int i = 0; i < NAME_BYTES; i++) begin
                           if (ncnt_in == NCNT_W'(i)) begin
                              nbuf_in[8*i +: 8] = c;
                           end
                        end
                        ncnt_in = NCNT_W'(ncnt_in + 1'b1);
                     end else begin
                        ntl_in = 1'b1;
                     end
                  end
                  if (mode_in.value && c != CHAR_EQUALS) begin
                     if (vcnt_in < VCNT_W'(VALUE_BYTES)) begin
                        for (int i = 0; i < VALUE_BYTES; i++) begin
                           if (vcnt_in == VCNT_W'(i)) begin
                              vbuf_in[8*i +: 8] = c;
                           end
                        end
                        vcnt_in = VCNT_W'(vcnt_in + 1'b1);
                     end else begin
                        vcut_in = 1'b1;
                     end
                  end
                  mode_in.line_start = 1'b0;
               end
            end
         end
         if (!done_in && c == CHAR_NEWLINE) begin
            mode_in.comment    = 1'b0;
            mode_in.section    = 1'b0;
            mode_in.key        = 1'b0;
            mode_in.value      = 1'b0;
            mode_in.key_match  = 1'b0;
            mode_in.line_start = 1'b1;
            nbuf_in = '0;
            ncnt_in = '0;
            ntl_in  = 1'b0;
            vbuf_in = '0;
            vcnt_in = '0;
            vcut_in = 1'b0;
         end
      end

      not_found = beat.is_last && !done_in;

      // The last byte of a text returns the scanner to its starting state.
      if (beat.is_last) begin
         mode_in = MODE_START;
         nbuf_in = '0;
         ncnt_in = '0;
         ntl_in  = 1'b0;
         vbuf_in = '0;
         vcnt_in = '0;
         vcut_in = 1'b0;
         done_in = 1'b0;
      end
   end

   assign result_valid = beat_valid && (emit || not_found);

   always_comb begin
      result.found          = emit;
      result.value_bytes    = emit ? 64'(vbuf_ff) : '0;
      result.value_length   = emit ? 4'(vcnt_ff) : '0;
      result.value_overflow = emit && vcut_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_name_ff    <= '0;
         section_length_ff  <= '0;
         key_name_ff        <= '0;
         key_length_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SECTION_NAME:   section_name_ff   <= csr_data;
            CSR_SECTION_LENGTH: section_length_ff <= csr_data[3:0];
            CSR_KEY_NAME:       key_name_ff       <= csr_data;
            CSR_KEY_LENGTH:     key_length_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_START;
         nbuf_ff            <= '0;
         ncnt_ff            <= '0;
         ntl_ff             <= 1'b0;
         vbuf_ff            <= '0;
         vcnt_ff            <= '0;
         vcut_ff            <= 1'b0;
         done_ff            <= 1'b0;
      end else if (beat_valid && advance) begin
         mode_ff <= mode_in;
         nbuf_ff <= nbuf_in;
         ncnt_ff <= ncnt_in;
         ntl_ff  <= ntl_in;
         vbuf_ff <= vbuf_in;
         vcnt_ff <= vcnt_in;
         vcut_ff <= vcut_in;
         done_ff <= done_in;
      end
   end

endmodule

### rtl/core/inikey_out_stage.sv
module inikey_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        result_valid,
   input  inikey_pkg::result_beat_type result,
   output logic                        take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [63:0]                 rsp_value_bytes,
   output logic [3:0]                  rsp_value_length,
   output logic                        rsp_value_overflow
);
   import inikey_pkg::*;

   logic            valid_ff;
   result_beat_type result_ff;

   // The slot is free when empty or when its beat leaves at this edge.
   assign take = !valid_ff || !rsp_stall;

   assign rsp_valid          = valid_ff;
   assign rsp_found          = result_ff.found;
   assign rsp_value_bytes    = result_ff.value_bytes;
   assign rsp_value_length   = result_ff.value_length;
   assign rsp_value_overflow = result_ff.value_overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= result_valid;
      end
      if (take && result_valid) begin
         result_ff <= result;
      end
   end

endmodule

### tb/tb_ini_section_key_lookup.sv
`timescale 1ns / 100ps

module tb_ini_section_key_lookup;
   import inikey_pkg::*;

   localparam int NAME_BYTES   = 8;
   localparam int VALUE_BYTES  = 8;
   localparam int LIMIT_CYCLES = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [63:0] rsp_value_bytes;
   logic [3:0]  rsp_value_length;
   logic        rsp_value_overflow;
   logic        csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SECTION_NAME;
   logic [63:0] csr_data = 64'h0;

   // Lookup settings as the scanner sees them.
   logic [63:0] want_section = 64'h0;
   logic [3:0]  want_section_len = 4'd0;
   logic [63:0] want_key = 64'h0;
   logic [3:0]  want_key_len = 4'd0;

   // Scanner state of the prediction.
   bit          in_comment, in_section, in_key, in_value;
   bit          at_line_start, section_hit, key_hit;
   logic [63:0] name_acc;
   int          name_len;
   bit          name_overrun;
   logic [63:0] value_acc;
   int          value_len;
   bit          value_clipped;
   bit          value_given;

   result_beat_type lookups_due[$];
   result_beat_type due;
   logic [7:0]      text_buf[$];

   bit idle_on = 1'b1;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int texts_sent = 0;
   int values_found = 0;
   int values_missed = 0;

   ini_section_key_lookup i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_value_bytes    (rsp_value_bytes),
      .rsp_value_length   (rsp_value_length),
      .rsp_value_overflow (rsp_value_overflow),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t ns: timeout with %0d results outstanding", $time, lookups_due.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   task automatic reset_scanner();
      in_comment    = 1'b0;
      in_section    = 1'b0;
      in_key        = 1'b0;
      in_value      = 1'b0;
      at_line_start = 1'b1;
      section_hit   = 1'b0;
      key_hit       = 1'b0;
      name_acc      = 64'h0;
      name_len      = 0;
      name_overrun  = 1'b0;
      value_acc     = 64'h0;
      value_len     = 0;
      value_clipped = 1'b0;
      value_given   = 1'b0;
   endtask

   function automatic bit name_equals(input logic [63:0] want, input logic [3:0] want_len);
      logic [63:0] mask;
      if (name_overrun || want_len > NAME_BYTES || name_len != want_len)
         return 1'b0;
      mask = (want_len >= 8) ? '1 : ((64'h1 << (8 * want_len)) - 64'h1);
      return name_acc == (want & mask);
   endfunction

   task automatic scan_text_byte(input logic [7:0] ch, input logic last);
      result_beat_type hit;
      bit              gave;
      bit              line_start;
      gave = 1'b0;
      if (!value_given) begin
         if (!in_comment) begin
            if (ch == CHAR_HASH) begin
               in_comment = 1'b1;
            end else begin
               line_start = at_line_start;
               if (ch == CHAR_LBRACK && line_start) begin
                  section_hit = 1'b0;
                  in_section  = 1'b1;
                  name_acc = 64'h0; name_len = 0; name_overrun = 1'b0;
               end
               if (ch != CHAR_LBRACK && line_start && section_hit) begin
                  in_key = 1'b1;
                  name_acc = 64'h0; name_len = 0; name_overrun = 1'b0;
               end
               if (ch == CHAR_RBRACK && in_section) begin
                  in_section = 1'b0;
                  if (name_equals(want_section, want_section_len))
                     section_hit = 1'b1;
               end
               if (ch == CHAR_EQUALS && in_key) begin
                  in_key   = 1'b0;
                  in_value = 1'b1;
                  key_hit  = name_equals(want_key, want_key_len);
                  value_acc = 64'h0; value_len = 0; value_clipped = 1'b0;
               end
               if ((ch == CHAR_NEWLINE || ch == CHAR_TAB || ch == CHAR_SPACE) &&
                   in_value && section_hit && key_hit) begin
                  hit.found          = 1'b1;
                  hit.value_bytes    = value_acc;
                  hit.value_length   = 4'(value_len);
                  hit.value_overflow = value_clipped;
                  gave        = 1'b1;
                  value_given = 1'b1;
               end else begin
                  if ((in_section && ch != CHAR_LBRACK) || in_key) begin
                     if (name_len < NAME_BYTES) begin
                        name_acc[8*name_len +: 8] = ch;
                        name_len++;
                     end else begin
                        name_overrun = 1'b1;
                     end
                  end
                  if (in_value && ch != CHAR_EQUALS) begin
                     if (value_len < VALUE_BYTES) begin
                        value_acc[8*value_len +: 8] = ch;
                        value_len++;
                     end else begin
                        value_clipped = 1'b1;
                     end
                  end
                  at_line_start = 1'b0;
               end
            end
         end
         if (!value_given && ch == CHAR_NEWLINE) begin
            in_comment    = 1'b0;
            in_section    = 1'b0;
            in_key        = 1'b0;
            in_value      = 1'b0;
            key_hit       = 1'b0;
            at_line_start = 1'b1;
            name_acc = 64'h0; name_len = 0; name_overrun = 1'b0;
            value_acc = 64'h0; value_len = 0; value_clipped = 1'b0;
         end
      end
      if (gave)
         lookups_due.push_back(hit);
      if (last) begin
         if (!value_given) begin
            hit = '0;
            lookups_due.push_back(hit);
         end
         reset_scanner();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input logic [63:0] expected,
                                  input logic [63:0] actual);
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, expected, actual);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (lookups_due.size() == 0) begin
            $display("%0t ns: result beat with none expected, expected none, got found=%b",
                     $time, rsp_found);
            mismatches++;
         end else begin
            due = lookups_due.pop_front();
            if (due.found) values_found++;
            else values_missed++;
            if (rsp_found !== due.found)
               report_mismatch("found", due.found, rsp_found);
            if (rsp_value_bytes !== due.value_bytes)
               report_mismatch("value_bytes", due.value_bytes, rsp_value_bytes);
            if (rsp_value_length !== due.value_length)
               report_mismatch("value_length", due.value_length, rsp_value_length);
            if (rsp_value_overflow !== due.value_overflow)
               report_mismatch("value_overflow", due.value_overflow, rsp_value_overflow);
         end
      end
   end

   // The receiver stalls in random bursts, or for one long stretch on request.
   initial begin : rsp_stall_gen
      int burst;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_beat(input logic [7:0] ch, input logic last);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      req_is_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      scan_text_byte(ch, last);
   endtask

   task automatic send_text_buf();
      for (int i = 0; i < text_buf.size(); i++)
         send_beat(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
      texts_sent++;
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endtask

   task automatic send_string(input string s);
      add_chars(s);
      send_text_buf();
   endtask

   task automatic wait_for_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (lookups_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      case (idx)
         CSR_SECTION_NAME:   want_section     = data;
         CSR_SECTION_LENGTH: want_section_len = data[3:0];
         CSR_KEY_NAME:       want_key         = data;
         CSR_KEY_LENGTH:     want_key_len     = data[3:0];
      endcase
   endtask

   // Length registers get random upper bits, which the block must ignore.
   task automatic program_lookup(input logic [63:0] sec, input logic [3:0] sec_len,
                                 input logic [63:0] key, input logic [3:0] key_len);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_csr(CSR_SECTION_NAME, sec);
      write_csr(CSR_SECTION_LENGTH, {junk[63:4], sec_len});
      write_csr(CSR_KEY_NAME, key);
      write_csr(CSR_KEY_LENGTH, {junk[31:0], junk[63:36], key_len});
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random text

   function automatic logic [7:0] random_letter();
      return 8'($urandom_range(97, 122));
   endfunction

   function automatic logic [7:0] random_value_char();
      int         pick;
      logic [7:0] ch;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return CHAR_EQUALS;
      if (pick < 3)
         return 8'($urandom_range(128, 255));
      ch = 8'($urandom_range(33, 126));
      return (ch == CHAR_HASH) ? 8'h78 : ch;
   endfunction

   function automatic logic [63:0] random_wanted_name(input int len);
      logic [63:0] name;
      name = {$urandom, $urandom};
      for (int i = 0; i < len; i++)
         name[8*i +: 8] = random_letter();
      return name;
   endfunction

   // Mostly the wanted name, otherwise a near miss or a random name.
   task automatic add_random_name(input logic [63:0] want, input logic [3:0] want_len);
      int n;
      int pick;
      n = (want_len > NAME_BYTES) ? NAME_BYTES : int'(want_len);
      pick = $urandom_range(0, 9);
      if (pick == 7 && n > 0)
         n--;
      if (pick < 8) begin
         for (int i = 0; i < n; i++)
            text_buf.push_back(want[8*i +: 8]);
         if (pick == 6)
            text_buf.push_back(random_letter());
      end else begin
         repeat ($urandom_range(0, 10)) text_buf.push_back(random_letter());
      end
   endtask

   task automatic build_random_text();
      int kind;
      int ending;
      repeat ($urandom_range(1, 4)) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            text_buf.push_back(CHAR_LBRACK);
            add_random_name(want_section, want_section_len);
            text_buf.push_back(CHAR_RBRACK);
            text_buf.push_back(CHAR_NEWLINE);
         end else if (kind < 7) begin
            add_random_name(want_key, want_key_len);
            text_buf.push_back(CHAR_EQUALS);
            repeat ($urandom_range(0, 11)) text_buf.push_back(random_value_char());
            ending = $urandom_range(0, 9);
            if (ending < 6) begin
               text_buf.push_back(CHAR_NEWLINE);
            end else if (ending == 6) begin
               text_buf.push_back(CHAR_SPACE);
            end else if (ending == 7) begin
               text_buf.push_back(CHAR_TAB);
            end else if (ending == 8) begin
               text_buf.push_back(CHAR_HASH);
               text_buf.push_back(random_letter());
               text_buf.push_back(CHAR_NEWLINE);
            end
         end else if (kind == 7) begin
            text_buf.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 5)) text_buf.push_back(8'($urandom_range(32, 126)));
            text_buf.push_back(CHAR_NEWLINE);
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_buf.push_back(CHAR_NEWLINE);
         end
      end
   endtask

   task automatic send_random_texts(input int min_beats, input int min_texts);
      int start_beats;
      int start_texts;
      start_beats = beats_sent;
      start_texts = texts_sent;
      while (beats_sent - start_beats < min_beats || texts_sent - start_texts < min_texts) begin
         build_random_text();
         send_text_buf();
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_found_values();
      program_lookup(64'h73, 4'd1, 64'h6B, 4'd1);
      send_string("[s]\nk=ab=c d\n");
      send_string("[s]\nk= \n");
      send_string("[s]\nk=123456789\t");
   endtask

   task automatic test_missed_values();
      send_string("[s]\n#k=v\nk=v#c\n");
      send_string("[ss]\nk=v\n[s]\nkk=v\n");
      send_string("[s]\nk=v");
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      texts_sent += 2;
   endtask

   task automatic test_name_extremes();
      wait_for_results(4);
      program_lookup('1, 4'd8, {8{8'hFE}}, 4'd8);
      text_buf.push_back(CHAR_LBRACK);
      repeat (9) text_buf.push_back(8'hFF);
      add_chars("]\n");
      repeat (8) text_buf.push_back(8'hFE);
      add_chars("=v\n");
      send_text_buf();
      text_buf.push_back(CHAR_LBRACK);
      repeat (8) text_buf.push_back(8'hFF);
      add_chars("]\n");
      repeat (8) text_buf.push_back(8'hFE);
      text_buf.push_back(CHAR_EQUALS);
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      text_buf.push_back(CHAR_NEWLINE);
      send_text_buf();
      send_random_texts(30, 4);
   endtask

   task automatic test_empty_names();
      wait_for_results(4);
      program_lookup(64'h0, 4'd0, 64'h0, 4'd0);
      send_string("[]\n=x\n");
      send_random_texts(30, 4);
   endtask

   task automatic test_oversized_length();
      wait_for_results(4);
      program_lookup(random_wanted_name(8), 4'd15, random_wanted_name(3), 4'd3);
      send_random_texts(30, 4);
   endtask

   // Results pile up behind a long receiver stall until the input side stalls.
   task automatic test_receiver_hold_off();
      wait_for_results(4);
      idle_on = 1'b0;
      program_lookup(64'h73, 4'd1, 64'h6B, 4'd1);
      hold_off_cycles = 300;
      repeat (10) send_string("[s]\nk=v\n");
      idle_on = 1'b1;
   endtask

   task automatic test_random_lookups();
      int sec_len;
      int key_len;
      for (int phase = 0; phase < 7; phase++) begin
         wait_for_results(4);
         sec_len = (phase == 0) ? 8 : $urandom_range(1, 8);
         key_len = (phase == 0) ? 8 : $urandom_range(1, 8);
         program_lookup(random_wanted_name(sec_len), 4'(sec_len),
                        random_wanted_name(key_len), 4'(key_len));
         send_random_texts(40, 3);
      end
   endtask

   task automatic test_quiet_tail();
      wait_for_results(4);
      idle_on = 1'b0;
      program_lookup(random_wanted_name(2), 4'd2, random_wanted_name(1), 4'd1);
      send_random_texts(40, 3);
   endtask

   initial begin
      reset_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_found_values();
      test_missed_values();
      test_name_extremes();
      test_empty_names();
      test_oversized_length();
      test_receiver_hold_off();
      test_random_lookups();
      test_quiet_tail();
      wait_for_results(8);
      $display("Covered %0d texts in %0d beats: %0d values found, %0d texts without a match.",
               texts_sent, beats_sent, values_found, values_missed);
      $display("Settings ranged over full, empty and over-long names, with one long stall.");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
